>>> rtl/core/sct_pkg.sv
// Package for the smartcard character transceiver.
// Holds the payload structs, ETU limits, command, status and phase codes.
// No dependencies.
package sct_pkg;

   // Width of the start-bit poll counter
   localparam int POLL_COUNT_BITS = 20;

   // ETU register: reset value is the default ETU factor of 372 divided by four
   localparam int ETU_FACTOR = 372;
   localparam logic [15:0] ETU_RESET = 16'(ETU_FACTOR / 4);
   localparam logic [15:0] ETU_MIN = 16'd8;

   // Polls taken when the request asks for zero
   localparam logic [POLL_COUNT_BITS-1:0] DEFAULT_POLLS = POLL_COUNT_BITS'(200000);

   // Command codes carried in mode
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_SEND = 2'd1;
   localparam logic [1:0] MODE_RECV = 2'd2;

   // Completion status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [1:0] STATUS_FALSE_START = 2'd2;

   // Frame engine phases
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_TX_START = 4'd1;
   localparam logic [3:0] PH_TX_DATA = 4'd2;
   localparam logic [3:0] PH_TX_PARITY = 4'd3;
   localparam logic [3:0] PH_TX_GUARD = 4'd4;
   localparam logic [3:0] PH_TX_TAIL = 4'd5;
   localparam logic [3:0] PH_RX_POLL = 4'd6;
   localparam logic [3:0] PH_RX_CONFIRM = 4'd7;
   localparam logic [3:0] PH_RX_DATA = 4'd8;
   localparam logic [3:0] PH_RX_PARITY = 4'd9;
   localparam logic [3:0] PH_RX_STOP = 4'd10;
   localparam logic [3:0] PH_RX_GUARD = 4'd11;
   localparam logic [3:0] PH_RX_TAIL = 4'd12;

   // One timer tick with its optional command
   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  tx_byte;
      logic [19:0] rx_timeout;
      logic        line_level;
   } req_type;

   // Line drive and status for one tick
   typedef struct packed {
      logic       line_release;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_byte;
      logic       parity_error;
      logic       stop_missing;
   } rsp_type;

endpackage

>>> rtl/core/sct_frame_engine.sv
// Character frame engine: phase sequencer, ETU tick counter and shift register.
// Advances by one tick per enabled cycle; result is combinational.
// Depends on sct_pkg.
module sct_frame_engine
   import sct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [15:0] etu_length,
   input  req_type     req,
   output rsp_type     res
);

   logic [3:0]                 phase_ff, phase_in;
   logic [15:0]                tick_ff, tick_in;
   logic [3:0]                 bit_ff, bit_in;
   logic [7:0]                 shift_ff, shift_in;
   logic                       par_acc_ff, par_acc_in;
   logic                       par_smp_ff, par_smp_in;
   logic                       stop_smp_ff, stop_smp_in;
   logic [POLL_COUNT_BITS-1:0] polls_ff, polls_in;

   logic [15:0] len_e, len_h, len_q;
   logic        tick_event;

   // Reload values for a full, half and quarter ETU (ETU is never below 8)
   assign len_e = etu_length - 16'd1;
   assign len_h = {1'b0, etu_length[15:1]} - 16'd1;
   assign len_q = {2'b00, etu_length[15:2]} - 16'd1;

   // Next state and result for one tick
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      par_acc_in  = par_acc_ff;
      par_smp_in  = par_smp_ff;
      stop_smp_in = stop_smp_ff;
      polls_in    = polls_ff;
      res         = '0;
      res.line_release = 1'b1;

      // Command decode, only when idle
      if (phase_ff == PH_IDLE) begin
         if (req.mode == MODE_SEND) begin
            phase_in   = PH_TX_START;
            tick_in    = len_e;
            shift_in   = req.tx_byte;
            par_acc_in = 1'b0;
            bit_in     = '0;
         end else if (req.mode == MODE_RECV) begin
            phase_in    = PH_RX_POLL;
            polls_in    = (req.rx_timeout != '0) ?
                          POLL_COUNT_BITS'(req.rx_timeout) : DEFAULT_POLLS;
            tick_in     = '0;
            shift_in    = '0;
            par_acc_in  = 1'b0;
            bit_in      = '0;
            par_smp_in  = 1'b0;
            stop_smp_in = 1'b0;
         end
      end

      // Line drive for this tick
      if (phase_in == PH_TX_START) begin
         res.line_release = 1'b0;
      end else if (phase_in == PH_TX_DATA) begin
         res.line_release = shift_in[0];
      end else if (phase_in == PH_TX_PARITY) begin
         res.line_release = par_acc_in;
      end

      // Interval countdown
      tick_event = (tick_in == '0);
      if (!tick_event) begin
         tick_in = tick_in - 16'd1;
      end

      // Phase transitions at interval end
      if (phase_in != PH_IDLE && tick_event) begin
         unique case (phase_in)
            PH_TX_START: begin
               phase_in = PH_TX_DATA;
               tick_in  = len_e;
            end
            PH_TX_DATA: begin
               par_acc_in = par_acc_in ^ shift_in[0];
               shift_in   = shift_in >> 1;
               bit_in     = bit_in + 4'd1;
               if (bit_in >= 4'd8) begin
                  phase_in = PH_TX_PARITY;
               end
               tick_in = len_e;
            end
            PH_TX_PARITY: begin
               phase_in = PH_TX_GUARD;
               tick_in  = len_e;
            end
            PH_TX_GUARD: begin
               phase_in = PH_TX_TAIL;
               tick_in  = len_h;
            end
            PH_TX_TAIL: begin
               phase_in     = PH_IDLE;
               res.done_res = 1'b1;
            end
            PH_RX_POLL: begin
               if (!req.line_level) begin
                  phase_in = PH_RX_CONFIRM;
                  tick_in  = len_h;
               end else if (polls_in == '0) begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = STATUS_TIMEOUT;
               end else begin
                  polls_in = polls_in - POLL_COUNT_BITS'(1);
                  tick_in  = len_q;
               end
            end
            PH_RX_CONFIRM: begin
               if (req.line_level) begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = STATUS_FALSE_START;
               end else begin
                  phase_in = PH_RX_DATA;
                  tick_in  = len_e;
               end
            end
            PH_RX_DATA: begin
               shift_in[bit_in[2:0]] = shift_in[bit_in[2:0]] | req.line_level;
               par_acc_in = par_acc_in ^ req.line_level;
               bit_in     = bit_in + 4'd1;
               if (bit_in >= 4'd8) begin
                  phase_in = PH_RX_PARITY;
               end
               tick_in = len_e;
            end
            PH_RX_PARITY: begin
               par_smp_in = req.line_level;
               phase_in   = PH_RX_STOP;
               tick_in    = len_e;
            end
            PH_RX_STOP: begin
               stop_smp_in = req.line_level;
               phase_in    = PH_RX_GUARD;
               tick_in     = len_e;
            end
            PH_RX_GUARD: begin
               phase_in = PH_RX_TAIL;
               tick_in  = len_h;
            end
            PH_RX_TAIL: begin
               phase_in         = PH_IDLE;
               res.done_res     = 1'b1;
               res.status       = STATUS_OK;
               res.rx_byte      = shift_in;
               res.parity_error = par_acc_in ^ par_smp_in;
               res.stop_missing = !stop_smp_in;
            end
            default: begin
               // unused phase codes fall back to idle
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase
      end

      res.busy_res = (phase_in != PH_IDLE);
   end

   // State registers, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         par_acc_ff  <= 1'b0;
         par_smp_ff  <= 1'b0;
         stop_smp_ff <= 1'b0;
         polls_ff    <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         par_acc_ff  <= par_acc_in;
         par_smp_ff  <= par_smp_in;
         stop_smp_ff <= stop_smp_in;
         polls_ff    <= polls_in;
      end
   end

endmodule

>>> rtl/core/smartcard_character_transceiver.sv
// Smartcard character transceiver, top level.
// ETU register, request handshake and response register around the frame engine.
// Depends on sct_pkg and sct_frame_engine.
//
// Usage:
//  - req channel: one transaction per timer tick, carrying the sampled I/O
//    line and an optional command (send a byte, or receive one with a
//    start-bit timeout in quarter-ETU polls). Commands are ignored while busy.
//  - rsp channel: exactly one transaction per request, giving the line drive
//    for that tick, busy, done and on completion the status, received byte,
//    parity and stop-bit error flags.
//  - csr channel: writes the ETU length in ticks, clamped to 8..65535. Write
//    only while no operation is running. Always ready.
//  - Responses are registered: a request's response is valid in the cycle
//    after it is accepted. Throughput is one request per cycle while rsp_ready
//    is high, with the combinational frame engine update between the registers.
//  - When rsp_ready is low the response register holds and req_ready drops
//    until it is taken; engine state advances only on accepted requests.
//  - Reset returns the engine to idle, empties the response register and
//    loads the ETU length with 93.
module smartcard_character_transceiver
   import sct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   logic [15:0] etu_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     eng_res;
   logic        req_fire;

   // Handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // ETU register, clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         etu_ff <= ETU_RESET;
      end else if (csr_valid) begin
         etu_ff <= (csr_wdata < ETU_MIN) ? ETU_MIN : csr_wdata;
      end
   end

   sct_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_fire),
      .etu_length (etu_ff),
      .req        (req_payload),
      .res        (eng_res)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= eng_res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   a_etu_range: assert property (@(posedge clock) disable iff (reset)
      etu_ff >= ETU_MIN)
      else $error("ETU length below minimum");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_fields_only_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.done_res |->
         rsp_ff.status == STATUS_OK && rsp_ff.rx_byte == 8'd0 &&
         !rsp_ff.parity_error && !rsp_ff.stop_missing)
      else $error("completion fields set without done");

   a_drive_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.line_release |-> rsp_ff.busy_res)
      else $error("line driven low while idle");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

endmodule
